// ===== hdl/ctss_pkg.sv =====
// package for the compacting table with search and sort
// holds sizes, function and status codes and the sequencer state type; no dependencies
package ctss_pkg;

    localparam int Depth    = 64;
    localparam int Width    = 32;
    localparam int AddrBits = $clog2(Depth);
    localparam int CntBits  = $clog2(Depth + 1);

    typedef enum logic [2:0] {
        FN_APPEND = 3'd0,
        FN_DELETE = 3'd1,
        FN_FIND   = 3'd2,
        FN_READ   = 3'd3,
        FN_SORT   = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_RANGE   = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEL_RD,
        S_DEL_WR,
        S_FIND_RD,
        S_FIND_CMP,
        S_RD_WAIT,
        S_SORT_KEY,
        S_SORT_KWAIT,
        S_SORT_RD,
        S_SORT_CMP,
        S_DONE
    } state_t;

endpackage

// ===== hdl/compacting_table_with_search_sort.sv =====
// compacting table with search and sort, top level
// depends on ctss_pkg; the entry store is a one-port synchronous ram inside this module
//
// A table of up to 64 signed 32-bit entries with a fill count. Each input transaction
// carries one request and yields exactly one output transaction. All entries sit in
// a single synchronous ram (one read or one write per cycle, registered read data), so
// every operation goes through that one port: find reads and compares one entry at a
// time, delete reads each later entry and writes it one place down, and sort is an
// insertion sort that reads each key, then compares it with the entries below it and
// moves them up. One request is in flight at a time; the result sits in an output
// register and the next request is taken once it is taken.
// Entries never written are never read. Codes 5 to 7 do nothing and report ok.
module compacting_table_with_search_sort
    import ctss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // func[2:0], value[34:3], index[40:35], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status[1:0], found_index[7:2], read_value[39:8],
                                   // count[46:40], zero fill
);

    logic [Width-1:0] mem [Depth];
    logic [Width-1:0] rdata_reg;

    state_t state_reg, state_next;
    logic [CntBits-1:0]  cnt_reg, cnt_next;
    logic [Width-1:0]    val_reg, val_next;
    logic [CntBits-1:0]  i_reg, i_next;     // outer position
    logic [CntBits-1:0]  j_reg, j_next;     // inner position (sort)
    logic [Width-1:0]    key_reg, key_next;
    logic [1:0]          st_reg, st_next;
    logic [AddrBits-1:0] fidx_reg, fidx_next;
    logic [Width-1:0]    rv_reg, rv_next;
    logic                ov_reg, ov_next;

    // ram port controls
    logic                we;
    logic                re;
    logic [AddrBits-1:0] addr;
    logic [Width-1:0]    wdata;

    logic [2:0]          in_func;
    logic [Width-1:0]    in_value;
    logic [AddrBits-1:0] in_index;

    assign in_func  = s_tdata[2:0];
    assign in_value = s_tdata[34:3];
    assign in_index = s_tdata[40:35];

    assign s_tready = (state_reg == S_IDLE) && !ov_reg;
    assign m_tvalid = ov_reg;
    assign m_tdata  = {1'b0, cnt_reg, rv_reg, fidx_reg, st_reg};

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        key_reg  <= key_next;
        st_reg   <= st_next;
        fidx_reg <= fidx_next;
        rv_reg   <= rv_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        val_next   = val_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        key_next   = key_reg;
        st_next    = st_reg;
        fidx_next  = fidx_reg;
        rv_next    = rv_reg;
        ov_next    = ov_reg;
        we         = 1'b0;
        re         = 1'b0;
        addr       = '0;
        wdata      = key_reg;

        if (ov_reg && m_tready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    val_next  = in_value;
                    st_next   = ST_OK;
                    fidx_next = '0;
                    rv_next   = '0;
                    state_next = S_DONE;
                    unique case (in_func)
                        FN_APPEND:
                        begin
                            if (cnt_reg == CntBits'(Depth))
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                we       = 1'b1;
                                addr     = cnt_reg[AddrBits-1:0];
                                wdata    = in_value;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        FN_DELETE:
                        begin
                            if ({1'b0, in_index} >= cnt_reg)
                            begin
                                st_next = ST_RANGE;
                            end
                            else
                            begin
                                i_next     = {1'b0, in_index};
                                state_next = S_DEL_RD;
                            end
                        end
                        FN_FIND:
                        begin
                            st_next    = ST_MISSING;
                            i_next     = '0;
                            state_next = S_FIND_RD;
                        end
                        FN_READ:
                        begin
                            if ({1'b0, in_index} >= cnt_reg)
                            begin
                                st_next = ST_RANGE;
                            end
                            else
                            begin
                                re         = 1'b1;
                                addr       = in_index;
                                state_next = S_RD_WAIT;
                            end
                        end
                        FN_SORT:
                        begin
                            i_next     = CntBits'(1);
                            state_next = S_SORT_KEY;
                        end
                        default: ;
                    endcase
                end
            end
            S_DEL_RD:
            begin
                if (i_reg + 1'b1 >= cnt_reg)
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    re         = 1'b1;
                    addr       = AddrBits'(i_reg + 1'b1);
                    state_next = S_DEL_WR;
                end
            end
            S_DEL_WR:
            begin
                we         = 1'b1;
                addr       = i_reg[AddrBits-1:0];
                wdata      = rdata_reg;
                i_next     = i_reg + 1'b1;
                state_next = S_DEL_RD;
            end
            S_FIND_RD:
            begin
                if (i_reg >= cnt_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    re         = 1'b1;
                    addr       = i_reg[AddrBits-1:0];
                    state_next = S_FIND_CMP;
                end
            end
            S_FIND_CMP:
            begin
                if (rdata_reg == val_reg)
                begin
                    st_next    = ST_OK;
                    fidx_next  = i_reg[AddrBits-1:0];
                    state_next = S_DONE;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_FIND_RD;
                end
            end
            S_RD_WAIT:
            begin
                rv_next    = rdata_reg;
                state_next = S_DONE;
            end
            S_SORT_KEY:
            begin
                if (i_reg >= cnt_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    re         = 1'b1;
                    addr       = i_reg[AddrBits-1:0];
                    j_next     = i_reg;
                    state_next = S_SORT_KWAIT;
                end
            end
            S_SORT_KWAIT:
            begin
                key_next   = rdata_reg;
                state_next = S_SORT_RD;
            end
            S_SORT_RD:
            begin
                // j is the hole; look at the entry just below it
                if (j_reg == '0)
                begin
                    we         = 1'b1;
                    addr       = '0;
                    wdata      = key_reg;
                    i_next     = i_reg + 1'b1;
                    state_next = S_SORT_KEY;
                end
                else
                begin
                    re         = 1'b1;
                    addr       = AddrBits'(j_reg - 1'b1);
                    state_next = S_SORT_CMP;
                end
            end
            S_SORT_CMP:
            begin
                we = 1'b1;
                addr = j_reg[AddrBits-1:0];
                if ($signed(key_reg) < $signed(rdata_reg))
                begin
                    wdata      = rdata_reg;
                    j_next     = j_reg - 1'b1;
                    state_next = S_SORT_RD;
                end
                else
                begin
                    wdata      = key_reg;
                    i_next     = i_reg + 1'b1;
                    state_next = S_SORT_KEY;
                end
            end
            S_DONE:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== hdl/ctss_checker.sv =====
// port-level checks for compacting_table_with_search_sort
// depends on ctss_pkg; bound to the top level below
module ctss_checker
    import ctss_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    // one request in flight: no new transaction while a result waits
    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input accepted while result pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[46:40] <= 7'(Depth))
        else $error("count above depth");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] == ST_FULL |-> m_tdata[46:40] == 7'(Depth))
        else $error("full reported below depth");

    a_find_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] == ST_MISSING |-> m_tdata[7:2] == '0)
        else $error("not found with nonzero index");

endmodule

bind compacting_table_with_search_sort ctss_checker u_ctss_checker (.*);
